// ===== rtl/thermistor_code_to_temperature_core_assert.svh =====
// Assertion macros for the thermistor code to temperature core.
`ifndef THERMISTOR_CODE_TO_TEMPERATURE_CORE_ASSERT_SVH
`define THERMISTOR_CODE_TO_TEMPERATURE_CORE_ASSERT_SVH

// cond must hold at every edge out of reset
`define TCTT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// cons must hold at the same edge as ante
`define TCTT_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tctt_pkg.sv =====
// Shared constants, tables and types of the thermistor code to temperature core.
package tctt_pkg;

  localparam int TABLE_POINTS = 17;
  localparam int CODE_W       = 14;
  localparam int MILLI_W      = 20;
  localparam int DECI_W       = 14;
  localparam int IDX_W        = $clog2(TABLE_POINTS);

  // interpolation widths, set by the table contents
  localparam int DEN_W   = 11;   // widest segment span in codes
  localparam int DT_W    = 13;   // temperature step per segment, millidegrees
  localparam int QUO_W   = 13;   // interpolated offset is below the step
  localparam int NUM_W   = 23;   // step times offset within segment
  localparam int TRIAL_W = DEN_W + QUO_W - 1;

  localparam int DIE_OFFSET_MC  = 22000;
  localparam int DIE_ZERO_CODE  = 7274;
  localparam int DIE_STEP_MC    = 50;
  localparam int MILLI_PER_DEG  = 1000;
  localparam int MILLI_PER_DECI = 100;

  // truncating /100 by reciprocal multiply
  localparam int MAG_W     = MILLI_W - 1;
  localparam int DIV_SHIFT = 26;
  localparam int RECIP_W   = 20;
  localparam int PROD_W    = MAG_W + RECIP_W;
  localparam longint unsigned DECI_RECIP_L =
    ((longint'(1) << DIV_SHIFT) + MILLI_PER_DECI - 1) / MILLI_PER_DECI;
  localparam logic [RECIP_W-1:0] DECI_RECIP = RECIP_W'(DECI_RECIP_L);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // descending breakpoint codes and their temperatures in degrees
  localparam logic [CODE_W-1:0] NTC_CODE [TABLE_POINTS] = '{
    14'h189c, 14'h1398, 14'h0fba, 14'h0cb8, 14'h0a5a, 14'h0878, 14'h06f2,
    14'h05b8, 14'h04b8, 14'h03e8, 14'h0340, 14'h02b8, 14'h0248, 14'h01ec,
    14'h01a2, 14'h0162, 14'h0130
  };
  localparam int NTC_DEG [TABLE_POINTS] = '{
    -20, -15, -10, -5, 0, 5, 10, 15, 20, 25, 30, 35, 40, 45, 50, 55, 60
  };

  typedef enum logic [1:0] {
    CLS_DIE,
    CLS_COLD,
    CLS_HOT,
    CLS_SEGMENT
  } cls_e;

  // work handed from front to back: result = base + floor(num / den)
  typedef struct packed {
    logic signed [MILLI_W-1:0] base;
    logic [NUM_W-1:0]          num;
    logic [DEN_W-1:0]          den;
  } tctt_req_t;

endpackage

// ===== rtl/tctt_front.sv =====
// Front end: classifies the code, picks the table segment and forms the division request.
module tctt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                sensor_kind_i,
  input  logic [tctt_pkg::CODE_W-1:0] raw_code_i,
  output logic                req_valid_o,
  input  logic                req_ready_i,
  output tctt_pkg::tctt_req_t req_o
);

  logic                            adv;
  logic                            a_vld_q;
  tctt_pkg::cls_e                  a_cls_q, a_cls_d;
  logic [tctt_pkg::IDX_W-1:0]      a_seg_q, a_seg_d;
  logic [tctt_pkg::CODE_W-1:0]     a_code_q;
  logic                            b_vld_q;
  tctt_pkg::tctt_req_t             b_req_q, b_req_d;

  logic [tctt_pkg::IDX_W-1:0]      seg_nxt;
  logic [tctt_pkg::CODE_W-1:0]     hi_code, lo_code;
  logic [tctt_pkg::DEN_W-1:0]      span;
  logic [tctt_pkg::DT_W-1:0]       dt;
  logic [tctt_pkg::DT_W+tctt_pkg::DEN_W-1:0] prod;
  logic signed [tctt_pkg::CODE_W:0] die_diff;

  assign adv        = !b_vld_q || req_ready_i;
  assign in_ready_o = adv;

  // stage A: classify, search segment (first j with code >= lower breakpoint)
  always_comb begin
    a_seg_d = '0;
    for (int j = tctt_pkg::TABLE_POINTS - 2; j >= 0; j--) begin
      if (raw_code_i >= tctt_pkg::NTC_CODE[j+1]) a_seg_d = tctt_pkg::IDX_W'(j);
    end
    if (sensor_kind_i) begin
      a_cls_d = tctt_pkg::CLS_DIE;
    end else if (raw_code_i >= tctt_pkg::NTC_CODE[0]) begin
      a_cls_d = tctt_pkg::CLS_COLD;
    end else if (raw_code_i <= tctt_pkg::NTC_CODE[tctt_pkg::TABLE_POINTS-1]) begin
      a_cls_d = tctt_pkg::CLS_HOT;
    end else begin
      a_cls_d = tctt_pkg::CLS_SEGMENT;
    end
  end

  // stage B: build request
  assign seg_nxt  = a_seg_q + tctt_pkg::IDX_W'(1);
  assign hi_code  = tctt_pkg::NTC_CODE[a_seg_q];
  assign lo_code  = tctt_pkg::NTC_CODE[seg_nxt];
  assign span     = tctt_pkg::DEN_W'(hi_code - a_code_q);
  assign dt       = tctt_pkg::DT_W'((tctt_pkg::NTC_DEG[seg_nxt] - tctt_pkg::NTC_DEG[a_seg_q])
                                    * tctt_pkg::MILLI_PER_DEG);
  assign prod     = dt * span;
  assign die_diff = $signed({1'b0, tctt_pkg::CODE_W'(tctt_pkg::DIE_ZERO_CODE)})
                  - $signed({1'b0, a_code_q});

  always_comb begin
    b_req_d.num = '0;
    b_req_d.den = tctt_pkg::DEN_W'(1);
    case (a_cls_q)
      tctt_pkg::CLS_DIE: begin
        b_req_d.base = tctt_pkg::MILLI_W'(tctt_pkg::DIE_OFFSET_MC
                                          + int'(die_diff) * tctt_pkg::DIE_STEP_MC);
      end
      tctt_pkg::CLS_COLD: begin
        b_req_d.base = tctt_pkg::MILLI_W'(tctt_pkg::NTC_DEG[0] * tctt_pkg::MILLI_PER_DEG);
      end
      tctt_pkg::CLS_HOT: begin
        b_req_d.base = tctt_pkg::MILLI_W'(tctt_pkg::NTC_DEG[tctt_pkg::TABLE_POINTS-1]
                                          * tctt_pkg::MILLI_PER_DEG);
      end
      tctt_pkg::CLS_SEGMENT: begin
        b_req_d.base = tctt_pkg::MILLI_W'(tctt_pkg::NTC_DEG[a_seg_q] * tctt_pkg::MILLI_PER_DEG);
        b_req_d.num  = prod[tctt_pkg::NUM_W-1:0];
        b_req_d.den  = tctt_pkg::DEN_W'(hi_code - lo_code);
      end
      default: begin
        b_req_d.base = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_cls_q  <= a_cls_d;
      a_seg_q  <= a_seg_d;
      a_code_q <= raw_code_i;
      b_req_q  <= b_req_d;
    end
  end

  assign req_valid_o = b_vld_q;
  assign req_o       = b_req_q;

endmodule

// ===== rtl/tctt_queue.sv =====
// Short request queue between front and back ends.
module tctt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  tctt_pkg::tctt_req_t push_req_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output tctt_pkg::tctt_req_t pop_req_o
);

  tctt_pkg::tctt_req_t          mem_q [tctt_pkg::QUEUE_DEPTH];
  logic [tctt_pkg::QPTR_W-1:0]  wptr_q, rptr_q;
  logic [tctt_pkg::QCNT_W-1:0]  cnt_q;
  logic                         push, pop;

  assign push_ready_o = cnt_q != tctt_pkg::QCNT_W'(tctt_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_req_o    = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + tctt_pkg::QPTR_W'(1);
      if (pop)  rptr_q <= rptr_q + tctt_pkg::QPTR_W'(1);
      if (push && !pop) begin
        cnt_q <= cnt_q + tctt_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - tctt_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_req_i;
  end

endmodule

// ===== rtl/tctt_back.sv =====
// Back end: pipelined restoring divide, sum, and tenths by reciprocal multiply.
module tctt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  tctt_pkg::tctt_req_t req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [tctt_pkg::MILLI_W-1:0] temp_milli_c_o,
  output logic signed [tctt_pkg::DECI_W-1:0]  temp_deci_c_o
);

  localparam int QW = tctt_pkg::QUO_W;

  logic                                adv;
  logic [QW:0]                         vld_q;
  logic [tctt_pkg::NUM_W-1:0]          rem_q  [QW];
  logic [tctt_pkg::DEN_W-1:0]          den_q  [QW];
  logic [QW-1:0]                       quo_q  [QW+1];
  logic signed [tctt_pkg::MILLI_W-1:0] base_q [QW+1];

  logic                                sum_vld_q, sum_neg_q;
  logic signed [tctt_pkg::MILLI_W-1:0] sum_milli_q, sum_milli_d, sum_abs;
  logic [tctt_pkg::MAG_W-1:0]          sum_mag_q;
  logic                                mul_vld_q, mul_neg_q;
  logic signed [tctt_pkg::MILLI_W-1:0] mul_milli_q;
  logic [tctt_pkg::PROD_W-1:0]         mul_prod_q;
  logic                                out_vld_q;
  logic [tctt_pkg::DECI_W-2:0]         deci_mag;
  logic signed [tctt_pkg::DECI_W-1:0]  deci_d;

  assign adv         = !out_vld_q || out_ready_i;
  assign req_ready_o = adv;

  // load stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else if (adv) vld_q[0] <= req_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0]  <= req_i.num;
      den_q[0]  <= req_i.den;
      quo_q[0]  <= '0;
      base_q[0] <= req_i.base;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar s = 1; s <= QW; s++) begin : g_div
    localparam int ShiftBit = QW - s;
    logic [tctt_pkg::TRIAL_W-1:0] trial;
    logic                         take;

    assign trial = tctt_pkg::TRIAL_W'(den_q[s-1]) << ShiftBit;
    assign take  = tctt_pkg::TRIAL_W'(rem_q[s-1]) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[s] <= 1'b0;
      else if (adv) vld_q[s] <= vld_q[s-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        quo_q[s]  <= quo_q[s-1] | (take ? (QW'(1) << ShiftBit) : '0);
        base_q[s] <= base_q[s-1];
      end
    end

    if (s < QW) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rem_q[s] <= take ? rem_q[s-1] - tctt_pkg::NUM_W'(trial) : rem_q[s-1];
          den_q[s] <= den_q[s-1];
        end
      end
    end
  end

  assign sum_milli_d = base_q[QW]
                     + $signed({{(tctt_pkg::MILLI_W-QW){1'b0}}, quo_q[QW]});
  assign sum_abs     = sum_milli_d[tctt_pkg::MILLI_W-1] ? -sum_milli_d : sum_milli_d;
  assign deci_mag    = mul_prod_q[tctt_pkg::DIV_SHIFT +: tctt_pkg::DECI_W-1];
  assign deci_d      = mul_neg_q ? -$signed({1'b0, deci_mag}) : $signed({1'b0, deci_mag});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
      mul_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      sum_vld_q <= vld_q[QW];
      mul_vld_q <= sum_vld_q;
      out_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_milli_q    <= sum_milli_d;
      sum_neg_q      <= sum_milli_d[tctt_pkg::MILLI_W-1];
      mul_milli_q    <= sum_milli_q;
      mul_neg_q      <= sum_neg_q;
      mul_prod_q     <= sum_mag_q * tctt_pkg::DECI_RECIP;
      temp_milli_c_o <= mul_milli_q;
      temp_deci_c_o  <= deci_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) sum_mag_q <= sum_abs[tctt_pkg::MAG_W-1:0];
  end

  assign out_valid_o = out_vld_q;

endmodule

// ===== rtl/thermistor_code_to_temperature_core.sv =====
// Throughput: one request per cycle while neither side stalls; the back end divides one quotient bit per stage
// over 13 stages, so every stage holds its own request.
// A four-entry queue parts front and back, so either side may stall alone.
// Reset: rst_ni asynchronous, active low; clears all valid flags and the queue pointers.
`include "thermistor_code_to_temperature_core_assert.svh"

module thermistor_code_to_temperature_core (
  input  logic clk_i,
  input  logic rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          sensor_kind_i,
  input  logic [tctt_pkg::CODE_W-1:0]   raw_code_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [tctt_pkg::MILLI_W-1:0] temp_milli_c_o,
  output logic signed [tctt_pkg::DECI_W-1:0]  temp_deci_c_o
);

  // Front: two stages. Stage A classifies the request (die code, clamped cold,
  // clamped hot, or inside a table segment) and finds the bracketing segment
  // with a row of parallel compares. Stage B forms base + num / den.
  logic                push_valid, push_ready;
  tctt_pkg::tctt_req_t push_req;

  tctt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sensor_kind_i (sensor_kind_i),
    .raw_code_i    (raw_code_i),
    .req_valid_o   (push_valid),
    .req_ready_i   (push_ready),
    .req_o         (push_req)
  );

  // Queue: decouples the front from back-end stalls.
  logic                pop_valid, pop_ready;
  tctt_pkg::tctt_req_t pop_req;

  tctt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_req_i   (push_req),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_req_o    (pop_req)
  );

  // Back: restoring divide pipeline, then sum, reciprocal multiply for tenths,
  // and the output register. Whole back end stalls only while a result waits.
  tctt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (pop_valid),
    .req_ready_o    (pop_ready),
    .req_i          (pop_req),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .temp_milli_c_o (temp_milli_c_o),
    .temp_deci_c_o  (temp_deci_c_o)
  );

  // Divisor is never zero, else the divide stages would set every quotient bit.
  `TCTT_ASSERT_IMPLIES(a_den_nonzero, push_valid && push_ready, push_req.den != '0, "zero divisor queued")

  // Tenths carry the sign of the millidegrees unless truncated to zero.
  `TCTT_ASSERT_IMPLIES(a_deci_sign, out_valid_o, (temp_deci_c_o == '0) || (temp_deci_c_o[tctt_pkg::DECI_W-1] == temp_milli_c_o[tctt_pkg::MILLI_W-1]), "tenths sign mismatch")

  // Result stays within the die code range, which spans the thermistor range.
  `TCTT_ASSERT_IMPLIES(a_milli_range, out_valid_o, (temp_milli_c_o >= -433450) && (temp_milli_c_o <= 385700), "millidegrees out of range")

endmodule

// ===== test/tb_thermistor_code_to_temperature_core.sv =====
// Self-checking testbench for the thermistor code to temperature core.
module tb_thermistor_code_to_temperature_core;
  import tctt_pkg::*;

  localparam logic KIND_NTC = 1'b0;
  localparam logic KIND_DIE = 1'b1;

  localparam int  MAX_GAP     = 15;
  localparam int  DRAIN_WAIT  = 40;      // comfortably past the pipeline latency
  localparam int  CYCLE_LIMIT = 400000;

  // Breakpoints of the thermistor curve, descending codes, degrees C.
  localparam int BP_CODE [TABLE_POINTS] = '{
    'h189c, 'h1398, 'h0fba, 'h0cb8, 'h0a5a, 'h0878, 'h06f2, 'h05b8, 'h04b8,
    'h03e8, 'h0340, 'h02b8, 'h0248, 'h01ec, 'h01a2, 'h0162, 'h0130
  };
  localparam int BP_DEG [TABLE_POINTS] = '{
    -20, -15, -10, -5, 0, 5, 10, 15, 20, 25, 30, 35, 40, 45, 50, 55, 60
  };

  typedef struct {
    logic signed [MILLI_W-1:0] milli;
    logic signed [DECI_W-1:0]  deci;
  } temp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      sensor_kind = KIND_NTC;
  logic [CODE_W-1:0]         raw_code = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [MILLI_W-1:0] temp_milli;
  logic signed [DECI_W-1:0]  temp_deci;

  temp_t temp_q[$];
  int    error_count = 0;
  int    cycle_count = 0;
  bit    no_idle = 1'b0;   // both sides run without gaps while set

  always #2 clk_i = ~clk_i;

  thermistor_code_to_temperature_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .sensor_kind_i  (sensor_kind),
    .raw_code_i     (raw_code),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .temp_milli_c_o (temp_milli),
    .temp_deci_c_o  (temp_deci)
  );

  // Temperature for one code: clamp at the table ends, else interpolate with
  // a floor division over the segment; die codes map on a straight line.
  function automatic temp_t predict_temp(input logic kind, input logic [CODE_W-1:0] code);
    longint m;
    longint c;
    longint hi;
    longint lo;
    longint dt;
    longint d;
    bit     found;
    temp_t  r;
    c = code;
    m = 0;
    found = 1'b0;
    if (kind == KIND_DIE) begin
      m = DIE_OFFSET_MC + (DIE_ZERO_CODE - c) * DIE_STEP_MC;
    end else if (c >= BP_CODE[0]) begin
      m = BP_DEG[0] * MILLI_PER_DEG;
    end else if (c <= BP_CODE[TABLE_POINTS-1]) begin
      m = BP_DEG[TABLE_POINTS-1] * MILLI_PER_DEG;
    end else begin
      for (int i = 0; i < TABLE_POINTS - 1; i++) begin
        hi = BP_CODE[i];
        lo = BP_CODE[i+1];
        if (!found && c <= hi && c >= lo) begin
          dt = (BP_DEG[i+1] - BP_DEG[i]) * MILLI_PER_DEG;
          // numerator and span are both non-negative, so floor is truncation
          m = BP_DEG[i] * MILLI_PER_DEG + (dt * (hi - c)) / (hi - lo);
          found = 1'b1;
        end
      end
    end
    d = m / MILLI_PER_DECI;
    r.milli = m[MILLI_W-1:0];
    r.deci  = d[DECI_W-1:0];
    return r;
  endfunction

  // Scoreboard: check each accepted result against the oldest expectation,
  // then queue the expectation for a request accepted at this edge.
  always @(posedge clk_i) begin
    temp_t exp_t;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (temp_q.size() == 0) begin
          $error("result with no request outstanding: milli %0d deci %0d",
                 temp_milli, temp_deci);
          error_count++;
        end else begin
          exp_t = temp_q.pop_front();
          if (temp_milli !== exp_t.milli) begin
            $error("temp_milli_c expected %0d actual %0d", exp_t.milli, temp_milli);
            error_count++;
          end
          if (temp_deci !== exp_t.deci) begin
            $error("temp_deci_c expected %0d actual %0d", exp_t.deci, temp_deci);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready)
        temp_q.push_back(predict_temp(sensor_kind, raw_code));
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random hold-off before each result, ready kept while waiting.
  initial begin
    int gap;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Send one request; returns at the edge where it was taken.
  task automatic send_code(input logic kind, input logic [CODE_W-1:0] code);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    sensor_kind <= kind;
    raw_code    <= code;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (temp_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [CODE_W-1:0] near_breakpoint();
    int idx;
    idx = $urandom_range(0, TABLE_POINTS - 1);
    return CODE_W'(BP_CODE[idx] + $urandom_range(0, 4) - 2);
  endfunction

  // Table ends, their neighbours, inner breakpoints and the die extremes.
  task automatic test_directed();
    send_code(KIND_NTC, '0);
    send_code(KIND_NTC, '1);
    send_code(KIND_NTC, CODE_W'(BP_CODE[0]));
    send_code(KIND_NTC, CODE_W'(BP_CODE[0] + 1));
    send_code(KIND_NTC, CODE_W'(BP_CODE[0] - 1));
    send_code(KIND_NTC, CODE_W'(BP_CODE[TABLE_POINTS-1]));
    send_code(KIND_NTC, CODE_W'(BP_CODE[TABLE_POINTS-1] + 1));
    send_code(KIND_NTC, CODE_W'(BP_CODE[TABLE_POINTS-1] - 1));
    send_code(KIND_NTC, CODE_W'(BP_CODE[4]));
    send_code(KIND_NTC, CODE_W'(BP_CODE[9]));
    send_code(KIND_NTC, CODE_W'(BP_CODE[1]));
    send_code(KIND_NTC, CODE_W'(BP_CODE[15]));
    send_code(KIND_NTC, CODE_W'(BP_CODE[1] + 1));
    send_code(KIND_NTC, CODE_W'(BP_CODE[15] - 1));
    send_code(KIND_NTC, 14'h2aaa);
    send_code(KIND_NTC, 14'h1555);
    send_code(KIND_DIE, '0);
    send_code(KIND_DIE, '1);
    send_code(KIND_DIE, CODE_W'(DIE_ZERO_CODE));
    send_code(KIND_DIE, CODE_W'(DIE_ZERO_CODE + 1));
    send_code(KIND_DIE, 14'd1);
    send_code(KIND_DIE, 14'h2aaa);
    send_code(KIND_DIE, 14'h1555);
  endtask

  // Thermistor codes: mostly on and around breakpoints or inside the curve,
  // the rest over the whole code space to exercise the clamps.
  task automatic test_thermistor_random(input int n);
    logic [CODE_W-1:0] code;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 2))
        0: code = near_breakpoint();
        1: code = CODE_W'($urandom_range(BP_CODE[TABLE_POINTS-1], BP_CODE[0]));
        default: code = CODE_W'($urandom());
      endcase
      send_code(KIND_NTC, code);
    end
  endtask

  task automatic test_die_random(input int n);
    for (int k = 0; k < n; k++)
      send_code(KIND_DIE, CODE_W'($urandom()));
  endtask

  // Sender stops until the pipeline is empty, then restarts.
  task automatic test_drain_pause();
    for (int k = 0; k < 20; k++)
      send_code(logic'($urandom_range(0, 1)), near_breakpoint());
    wait_all_results();
    for (int k = 0; k < 20; k++)
      send_code(logic'($urandom_range(0, 1)), CODE_W'($urandom()));
  endtask

  // Mixed traffic with stretches of back-to-back requests and results.
  task automatic test_mixed_bursts(input int n);
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0)
        no_idle = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1))
        send_code(KIND_DIE, CODE_W'($urandom()));
      else
        send_code(KIND_NTC, ($urandom_range(0, 1)) ? near_breakpoint() : CODE_W'($urandom()));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_thermistor_random(700);
    test_die_random(300);
    test_drain_pause();
    test_mixed_bursts(500);
    wait_all_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0 && temp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
